// ----- rtl/core/modexp_pkg.sv -----
`default_nettype none
package modexp_pkg;
	localparam int unsigned OPERAND_BITS_DEF = 32;
	localparam int unsigned EXPONENT_BITS_DEF = 32;
	localparam int unsigned IN_BYTES = (3 * 32 + 7) / 8;
	localparam int unsigned OUT_BYTES = (32 + 1 + 7) / 8;
endpackage
`default_nettype wire

// ----- rtl/core/modular_exponentiation_top.sv -----
`default_nettype none
// Modular exponentiation: power_result = base ^ exponent mod modulus.
// Input channel s_axis_*: one beat carries base, exponent and modulus.
// Output channel m_axis_*: one beat carries the result and a flag that is set
// when the modulus was zero (the result is then zero).
// The block is right-to-left binary exponentiation built around one shared
// modular multiplier. The multiplier works one multiplier bit per cycle by
// doubling and adding, each step reduced by compare and subtract. The base is
// first reduced by the same unit (base * 1 mod m). Each exponent bit costs a
// pass through the step state, one multiplication when the bit is set and one
// squaring. A zero modulus gives its result the cycle after accept.
// Only one item is in work at a time; s_axis_tready is high only when idle.
// The result is held in an output register until taken; while the receiver
// stalls, the block stays busy and accepts nothing new.
// Reset clears the sequencer and the output valid; no result is pending.
module modular_exponentiation_top #(
	parameter int unsigned OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF,
	parameter int unsigned EXPONENT_BITS = modexp_pkg::EXPONENT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// base [31:0], exponent [63:32], modulus [95:64]
	input wire logic [modexp_pkg::IN_BYTES*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// power_result [31:0], bad_modulus [32], zero fill above
	output logic [modexp_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
	localparam int unsigned OB = OPERAND_BITS;
	localparam int unsigned EB = EXPONENT_BITS;
	localparam int unsigned CW = $clog2(OB + 1);
	localparam int unsigned EW = $clog2(EB + 1);
	localparam int unsigned UB = (OB < 32) ? OB : 32;
	localparam int unsigned XB = (EB < 32) ? EB : 32;

	typedef enum logic [2:0] {
		ST_IDLE, ST_REDUCE, ST_MUL, ST_SQR, ST_NEXT, ST_DONE
	} state_t;

	state_t state_q;
	logic [OB-1:0] mod_q, sq_q, acc_q, ma_q, prod_q;
	logic [OB-1:0] mb_q;
	logic [EB-1:0] exp_q;
	logic [CW-1:0] bit_q;
	logic [EW-1:0] ebit_q;
	logic [31:0] res_q;
	logic bad_q;

	// One step of the shared multiplier: prod = 2*prod (+ a) mod m.
	logic [OB:0] dbl, dsub, add1, asub;
	logic [OB-1:0] dbl_r, step_r;
	always_comb begin
		dbl = {prod_q, 1'b0};
		dsub = dbl - {1'b0, mod_q};
		dbl_r = (dbl >= {1'b0, mod_q}) ? dsub[OB-1:0] : dbl[OB-1:0];
		add1 = {1'b0, dbl_r} + {1'b0, ma_q};
		asub = add1 - {1'b0, mod_q};
		if (mb_q[OB-1])
			step_r = (add1 >= {1'b0, mod_q}) ? asub[OB-1:0] : add1[OB-1:0];
		else
			step_r = dbl_r;
	end

	logic [OB-1:0] in_base, in_mod;
	logic [EB-1:0] in_exp;
	always_comb begin
		in_base = '0;
		in_mod = '0;
		in_exp = '0;
		in_base[UB-1:0] = s_axis_tdata[UB-1:0];
		in_exp[XB-1:0] = s_axis_tdata[32 +: XB];
		in_mod[UB-1:0] = s_axis_tdata[64 +: UB];
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_DONE);
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[31:0] = res_q;
		m_axis_tdata[32] = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						mod_q <= in_mod;
						exp_q <= in_exp;
						ebit_q <= EW'(EB);
						if (in_mod == '0) begin
							res_q <= '0;
							bad_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							bad_q <= 1'b0;
							// 1 mod m: zero when m is one.
							acc_q <= (in_mod == OB'(1)) ? '0 : OB'(1);
							// 1 * base mod m reduces the base; the addend is below m unless m is one.
							ma_q <= OB'(1);
							mb_q <= in_base;
							prod_q <= '0;
							bit_q <= CW'(OB);
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE, ST_MUL, ST_SQR: begin
					if (bit_q != '0) begin
						prod_q <= step_r;
						mb_q <= mb_q << 1;
						bit_q <= bit_q - CW'(1);
					end else begin
						if (state_q == ST_REDUCE) begin
							sq_q <= prod_q;
						end else if (state_q == ST_MUL) begin
							acc_q <= prod_q;
						end else begin
							sq_q <= prod_q;
						end
						if (state_q == ST_MUL) begin
							// Now square the running square.
							ma_q <= sq_q;
							mb_q <= sq_q;
							prod_q <= '0;
							bit_q <= CW'(OB);
							state_q <= ST_SQR;
						end else begin
							if (state_q == ST_SQR) begin
								exp_q <= exp_q >> 1;
								ebit_q <= ebit_q - EW'(1);
							end
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					prod_q <= '0;
					bit_q <= CW'(OB);
					if (ebit_q == '0) begin
						res_q <= 32'(acc_q);
						state_q <= ST_DONE;
					end else if (exp_q[0]) begin
						ma_q <= acc_q;
						mb_q <= sq_q;
						state_q <= ST_MUL;
					end else begin
						ma_q <= sq_q;
						mb_q <= sq_q;
						state_q <= ST_SQR;
					end
				end
				ST_DONE: begin
					if (m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
